// ----- rtl/level_alarm_hysteresis_averager_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the level alarm core
// Concurrent assertion wrappers, empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef LEVEL_ALARM_HYSTERESIS_AVERAGER_CORE_MACROS_SVH
`define LEVEL_ALARM_HYSTERESIS_AVERAGER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// check outside reset
`define LAH_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lah assertion failed");
// check at every edge, reset included
`define LAH_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lah assertion failed");
`else
`define LAH_ASSERT(label, clk, rst_n, prop)
`define LAH_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- rtl/lah_pkg.sv -----
// ---------------------------------------------------------------------------
// lah_pkg
// Shared widths, register indexes, reset values and types.
// ---------------------------------------------------------------------------
package lah_pkg;

  localparam int LEVEL_W     = 8;
  localparam int FEEDBACK_W  = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_LEVEL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_ENABLE = 2'd1;

  localparam logic [LEVEL_W-1:0]    THRESHOLD_RESET = 8'd70;
  localparam logic [FEEDBACK_W-1:0] FEEDBACK_RESET  = 2'b11;

  localparam int FB_LED_BIT = 0;
  localparam int FB_VIB_BIT = 1;

  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] level;
  } mean_t;

endpackage

// ----- rtl/lah_window.sv -----
// ---------------------------------------------------------------------------
// lah_window
// Block averager: accumulates levels and emits the truncated mean per window.
// ---------------------------------------------------------------------------
`include "level_alarm_hysteresis_averager_core_macros.svh"

module lah_window #(
  parameter int AVERAGE_BLOCKS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [lah_pkg::LEVEL_W-1:0] level,
  output lah_pkg::mean_t              mean
);

  localparam int FILL_W  = $clog2(AVERAGE_BLOCKS + 1);
  localparam int DIV_L   = $clog2(AVERAGE_BLOCKS);
  localparam int SUM_W   = lah_pkg::LEVEL_W + DIV_L;
  localparam int SHIFT   = SUM_W + DIV_L;
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  // ceil(2^SHIFT / N): exact floor division for any sum below 2^SUM_W
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(AVERAGE_BLOCKS) - 64'd1) / 64'(AVERAGE_BLOCKS);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic [FILL_W-1:0] fill_r, fill_nxt, fill_inc_w;
  logic [SUM_W-1:0]  sum_r, sum_nxt, sum_tot_w;
  logic [PROD_W-1:0] prod_w;
  logic              done_w;

  assign sum_tot_w  = sum_r + SUM_W'(level);
  assign fill_inc_w = fill_r + FILL_W'(1);
  assign done_w     = (fill_inc_w == FILL_W'(AVERAGE_BLOCKS));
  assign prod_w     = PROD_W'(sum_tot_w) * PROD_W'(RECIP);

  always_comb begin
    mean.valid = step && done_w;
    mean.level = done_w ? prod_w[SHIFT +: lah_pkg::LEVEL_W] : '0;
    fill_nxt   = fill_r;
    sum_nxt    = sum_r;
    if (step) begin
      // close the window or keep filling
      fill_nxt = done_w ? '0 : fill_inc_w;
      sum_nxt  = done_w ? '0 : sum_tot_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      sum_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  `LAH_ASSERT(a_fill_in_range, clk, rst_n, fill_r < FILL_W'(AVERAGE_BLOCKS))
  `LAH_ASSERT(a_window_clears, clk, rst_n, mean.valid |=> (fill_r == '0 && sum_r == '0))
  `LAH_ASSERT(a_hold_when_idle, clk, rst_n, !step |=> ($stable(fill_r) && $stable(sum_r)))

endmodule

// ----- rtl/level_alarm_hysteresis_averager_core.sv -----
// ---------------------------------------------------------------------------
// level_alarm_hysteresis_averager_core
// Loudness alarm with consecutive-block hysteresis plus a block averager.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in_     | input     | in_valid / in_ready  | in_level_db
//  out_    | output    | out_valid / out_ready| alarm, start cues, end, mean
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One transaction per cycle sustained while out_ready stays high; a result
//  reaches the out_ ports through the input register, which loads on the
//  accept edge, and then the result register.
//  Between the two lies a single pass through the run counters and averager.
//  out_ready low holds the result register; the input register still takes
//  one more transaction, then in_ready drops until the result moves.
//  rst_n is synchronous: counters, alarm, window and valids clear, the
//  threshold returns to 70 dB and both start cues are enabled.
//  cfg_ready is always high; writes to unknown indexes are dropped.
// ---------------------------------------------------------------------------
`include "level_alarm_hysteresis_averager_core_macros.svh"

module level_alarm_hysteresis_averager_core #(
  parameter int HOLD_COUNT     = 3,
  parameter int AVERAGE_BLOCKS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lah_pkg::LEVEL_W-1:0]     in_level_db,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_alarm_active,
  output logic                            out_start_led,
  output logic                            out_start_vibration,
  output logic                            out_alarm_end,
  output logic                            out_mean_valid,
  output logic [lah_pkg::LEVEL_W-1:0]     out_mean_level,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lah_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lah_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int RUN_W = $clog2(HOLD_COUNT + 1);
  localparam logic [RUN_W-1:0] HOLD = RUN_W'(HOLD_COUNT);

  // configuration registers
  logic [lah_pkg::LEVEL_W-1:0]    threshold_r;
  logic [lah_pkg::FEEDBACK_W-1:0] feedback_r;

  // input register
  logic                        s1_valid_r;
  logic [lah_pkg::LEVEL_W-1:0] s1_level_r;

  // hysteresis state
  logic [RUN_W-1:0] loud_r, loud_nxt;
  logic [RUN_W-1:0] quiet_r, quiet_nxt;
  logic             alarm_r, alarm_nxt;

  // result register
  logic                        out_valid_r;
  logic                        out_alarm_active_r;
  logic                        out_start_led_r;
  logic                        out_start_vibration_r;
  logic                        out_alarm_end_r;
  logic                        out_mean_valid_r;
  logic [lah_pkg::LEVEL_W-1:0] out_mean_level_r;

  logic           adv_w;      // result register free to load this cycle
  logic           step_w;     // input register item moves into the result
  logic           loud_w;
  logic           turn_on_w;
  logic           turn_off_w;
  lah_pkg::mean_t mean_w;

  // Advance the pipeline whenever the result slot is empty or being taken.
  assign adv_w     = !out_valid_r || out_ready;
  assign step_w    = s1_valid_r && adv_w;
  assign in_ready  = !s1_valid_r || adv_w;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= lah_pkg::THRESHOLD_RESET;
      feedback_r  <= lah_pkg::FEEDBACK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lah_pkg::REG_THRESHOLD_LEVEL: begin
          threshold_r <= cfg_data[lah_pkg::LEVEL_W-1:0];
        end
        lah_pkg::REG_FEEDBACK_ENABLE: begin
          feedback_r <= cfg_data[lah_pkg::FEEDBACK_W-1:0];
        end
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  // Input register: load on accept, drop the valid once it moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (adv_w) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_level_r <= in_level_db;
    end
  end

  // Hysteresis: a loud block extends the loud run and clears the quiet run,
  // a quiet block the reverse. Runs saturate at HOLD_COUNT, so reaching it
  // is an equality test.
  assign loud_w = (s1_level_r >= threshold_r);

  always_comb begin
    loud_nxt   = loud_r;
    quiet_nxt  = quiet_r;
    alarm_nxt  = alarm_r;
    turn_on_w  = 1'b0;
    turn_off_w = 1'b0;
    if (step_w) begin
      if (loud_w) begin
        loud_nxt  = (loud_r < HOLD) ? loud_r + RUN_W'(1) : loud_r;
        quiet_nxt = '0;
        turn_on_w = !alarm_r && (loud_nxt == HOLD);
      end else begin
        quiet_nxt  = (quiet_r < HOLD) ? quiet_r + RUN_W'(1) : quiet_r;
        loud_nxt   = '0;
        turn_off_w = alarm_r && (quiet_nxt == HOLD);
      end
      if (turn_on_w) begin
        alarm_nxt = 1'b1;
      end else if (turn_off_w) begin
        alarm_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loud_r  <= '0;
      quiet_r <= '0;
      alarm_r <= 1'b0;
    end else begin
      loud_r  <= loud_nxt;
      quiet_r <= quiet_nxt;
      alarm_r <= alarm_nxt;
    end
  end

  // Averaging window runs on the same step as the hysteresis.
  lah_window #(
    .AVERAGE_BLOCKS (AVERAGE_BLOCKS)
  ) u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step_w),
    .level (s1_level_r),
    .mean  (mean_w)
  );

  // Result register: load on step, clear the valid once taken, else hold.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_w) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_w) begin
      out_alarm_active_r    <= alarm_nxt;
      out_start_led_r       <= turn_on_w && feedback_r[lah_pkg::FB_LED_BIT];
      out_start_vibration_r <= turn_on_w && feedback_r[lah_pkg::FB_VIB_BIT];
      out_alarm_end_r       <= turn_off_w;
      out_mean_valid_r      <= mean_w.valid;
      out_mean_level_r      <= mean_w.level;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_alarm_active    = out_alarm_active_r;
  assign out_start_led       = out_start_led_r;
  assign out_start_vibration = out_start_vibration_r;
  assign out_alarm_end       = out_alarm_end_r;
  assign out_mean_valid      = out_mean_valid_r;
  assign out_mean_level      = out_mean_level_r;

  `LAH_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid_r)
  `LAH_ASSERT(a_runs_exclusive, clk, rst_n, !(loud_r != '0 && quiet_r != '0))
  `LAH_ASSERT(a_alarm_only_on_step, clk, rst_n, !step_w |=> $stable(alarm_r))
  `LAH_ASSERT(a_start_with_alarm, clk, rst_n, (out_valid_r && (out_start_led_r || out_start_vibration_r)) |-> out_alarm_active_r)
  `LAH_ASSERT(a_end_clears_alarm, clk, rst_n, (out_valid_r && out_alarm_end_r) |-> !out_alarm_active_r)

endmodule
